### sv/kbbs_pkg.sv
package kbbs_pkg;

    typedef logic [7:0] byte_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_EMIT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic shift;    // shift block toward position zero, new byte at the top
        logic round;    // apply one scramble round
        logic parity;   // swap parity at the start of this round
    } dp_cmd_t;

    // Configuration register indexes
    localparam logic [7:0] CFG_ROUNDS          = 8'd0;
    localparam logic [7:0] CFG_ROT_WHOLE       = 8'd1;
    localparam logic [7:0] CFG_ROT_FIRST_HALF  = 8'd2;
    localparam logic [7:0] CFG_ROT_SECOND_HALF = 8'd3;

    // Configuration widths and reset values
    localparam int ROUNDS_W = 16;
    localparam int ROT_WHOLE_W = 7;
    localparam int ROT_HALF_W = 6;

    localparam logic [ROUNDS_W-1:0]    ROUNDS_RST          = 16'd2023;
    localparam logic [ROT_WHOLE_W-1:0] ROT_WHOLE_RST       = 7'd23;
    localparam logic [ROT_HALF_W-1:0]  ROT_FIRST_HALF_RST  = 6'd13;
    localparam logic [ROT_HALF_W-1:0]  ROT_SECOND_HALF_RST = 6'd17;

endpackage

### sv/kbbs_dpath.sv
module kbbs_dpath #(
    parameter int SEED_LEN = 64
) (
    input  logic                                  clk,
    input  kbbs_pkg::dp_cmd_t                     cmd,
    input  kbbs_pkg::byte_t                       in_byte,
    input  logic [kbbs_pkg::ROT_WHOLE_W-1:0]      rot_whole,
    input  logic [kbbs_pkg::ROT_HALF_W-1:0]       rot_first_half,
    input  logic [kbbs_pkg::ROT_HALF_W-1:0]       rot_second_half,
    output kbbs_pkg::byte_t                       out_byte
);
    import kbbs_pkg::*;

    localparam int H = SEED_LEN / 2;
    localparam int Q = SEED_LEN / 4;
    localparam int NROT_HALF = 2 ** ROT_HALF_W;
    localparam int NROT_WHOLE = 2 ** ROT_WHOLE_W;

    byte_t blk_reg  [SEED_LEN];
    byte_t blk_next [SEED_LEN];
    byte_t v0 [SEED_LEN];
    byte_t v1 [SEED_LEN];
    byte_t sel [SEED_LEN];
    byte_t r1 [SEED_LEN];
    byte_t r2 [SEED_LEN];

    // Mirror swaps for both possible starting parities (fixed wiring)
    always_comb
    begin
        int    pa0;
        int    pa1;
        byte_t tmp;
        pa0 = 0;
        pa1 = 0;
        tmp = '0;
        v0 = blk_reg;
        v1 = blk_reg;
        for (int i = 0; i < Q; i++)
        begin
            // start parity even: even swap index pairs with H-1-i
            pa0 = ((i % 2) == 0) ? (H - 1 - i) : (H - 2 - i);
            pa1 = ((i % 2) == 0) ? (H - 2 - i) : (H - 1 - i);
            tmp = v0[i];       v0[i] = v0[pa0];         v0[pa0] = tmp;
            tmp = v0[H + i];   v0[H + i] = v0[H + pa0]; v0[H + pa0] = tmp;
            tmp = v1[i];       v1[i] = v1[pa1];         v1[pa1] = tmp;
            tmp = v1[H + i];   v1[H + i] = v1[H + pa1]; v1[H + pa1] = tmp;
        end
        for (int k = 0; k < SEED_LEN; k++)
            sel[k] = cmd.parity ? v1[k] : v0[k];
    end

    // Half rotations; amount reduced modulo H by constant wiring
    always_comb
    begin
        r1 = sel;
        for (int k = 0; k < H; k++)
        begin
            for (int a = 0; a < NROT_HALF; a++)
            begin
                if (rot_first_half == ROT_HALF_W'(a))
                    r1[k] = sel[(k + a) % H];
                if (rot_second_half == ROT_HALF_W'(a))
                    r1[H + k] = sel[H + ((k + a) % H)];
            end
        end
    end

    // Whole block rotation
    always_comb
    begin
        r2 = r1;
        for (int k = 0; k < SEED_LEN; k++)
        begin
            for (int a = 0; a < NROT_WHOLE; a++)
            begin
                if (rot_whole == ROT_WHOLE_W'(a))
                    r2[k] = r1[(k + a) % SEED_LEN];
            end
        end
    end

    // Next block value: shift for load/emit, round for scramble
    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.shift)
        begin
            for (int k = 0; k < SEED_LEN - 1; k++)
                blk_next[k] = blk_reg[k + 1];
            blk_next[SEED_LEN - 1] = in_byte;
        end
        else if (cmd.round)
        begin
            blk_next = r2;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

    assign out_byte = blk_reg[0];

endmodule

### sv/kbbs_ctrl.sv
module kbbs_ctrl #(
    parameter int SEED_LEN = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               m_tready,
    input  logic [kbbs_pkg::ROUNDS_W-1:0]      rounds,
    output logic                               s_tready,
    output logic                               m_tvalid,
    output logic                               m_tlast,
    output kbbs_pkg::dp_cmd_t                  cmd
);
    import kbbs_pkg::*;

    localparam int CNT_W = $clog2(SEED_LEN);
    localparam int Q = SEED_LEN / 4;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SEED_LEN - 1);
    localparam logic PAR_FLIP = 1'(Q % 2);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ROUNDS_W-1:0] round_reg, round_next;
    logic                parity_reg, parity_next;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            cnt_reg    <= '0;
            round_reg  <= '0;
            parity_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            round_reg  <= round_next;
            parity_reg <= parity_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        round_next  = round_reg;
        parity_next = parity_reg;
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        m_tlast     = 1'b0;
        cmd         = '{shift: 1'b0, round: 1'b0, parity: parity_reg};
        case (state_reg)
            ST_LOAD:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.shift = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_next    = '0;
                        round_next  = '0;
                        parity_next = 1'b1;
                        state_next  = (rounds == '0) ? ST_EMIT : ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.round   = 1'b1;
                parity_next = parity_reg ^ PAR_FLIP;
                round_next  = round_reg + 1'b1;
                if (round_reg == rounds - 1'b1)
                begin
                    round_next = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                m_tlast  = (cnt_reg == CNT_LAST);
                if (m_tready)
                begin
                    cmd.shift = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

### sv/keyed_byte_block_scrambler_top.sv
// Keyed byte block scrambler. Loads SEED_LEN seed bytes on the input stream
// (one per cycle, position zero first), then runs the configured number of
// rounds at one round per cycle: each round's mirror swaps and its three
// rotations are done by the combinational round datapath. The block then
// emits SEED_LEN bytes at one per cycle while m_tready is high, with tlast on
// the final byte. Input and output phases do not overlap. Configuration
// writes are taken at any time and are meant for when the block is idle.
module keyed_byte_block_scrambler_top #(
    parameter int SEED_LEN = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] seed_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_char
    output logic        m_tlast,    // last_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_addr,
    input  logic [15:0] cfg_data
);
    import kbbs_pkg::*;

    logic [ROUNDS_W-1:0]    rounds_reg;
    logic [ROT_WHOLE_W-1:0] rot_whole_reg;
    logic [ROT_HALF_W-1:0]  rot_first_half_reg;
    logic [ROT_HALF_W-1:0]  rot_second_half_reg;
    dp_cmd_t                cmd;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounds_reg          <= ROUNDS_RST;
            rot_whole_reg       <= ROT_WHOLE_RST;
            rot_first_half_reg  <= ROT_FIRST_HALF_RST;
            rot_second_half_reg <= ROT_SECOND_HALF_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                CFG_ROUNDS:          rounds_reg          <= cfg_data[ROUNDS_W-1:0];
                CFG_ROT_WHOLE:       rot_whole_reg       <= cfg_data[ROT_WHOLE_W-1:0];
                CFG_ROT_FIRST_HALF:  rot_first_half_reg  <= cfg_data[ROT_HALF_W-1:0];
                CFG_ROT_SECOND_HALF: rot_second_half_reg <= cfg_data[ROT_HALF_W-1:0];
                default:             ;
            endcase
        end
    end

    kbbs_ctrl #(
        .SEED_LEN (SEED_LEN)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .rounds   (rounds_reg),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .cmd      (cmd)
    );

    kbbs_dpath #(
        .SEED_LEN (SEED_LEN)
    ) u_dpath (
        .clk             (clk),
        .cmd             (cmd),
        .in_byte         (s_tdata),
        .rot_whole       (rot_whole_reg),
        .rot_first_half  (rot_first_half_reg),
        .rot_second_half (rot_second_half_reg),
        .out_byte        (m_tdata)
    );

    // Loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output phases overlap");

    // A transaction on the final byte returns the block to loading
    a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block did not return to loading after last byte");

    // Emission continues until the final byte is taken
    a_emit_cont: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("emission stopped before the last byte");

    // A round never runs on top of a shift
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift && cmd.round))
        else $error("shift and round commanded together");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import kbbs_pkg::*;

    localparam int SEED_LEN      = 64;
    localparam int HALF          = SEED_LEN / 2;
    localparam int QUARTER       = SEED_LEN / 4;
    localparam int HALF_PERIOD   = 6;
    // Longest quiet stretch: 65535 rounds with no transaction, taken three times over
    localparam int STALL_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 2 * SEED_LEN + 16;

    typedef struct packed {
        byte_t ch;
        logic  last;
    } scr_out_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_addr;
    logic [15:0] cfg_data;

    // Predictor state: block under load and the settings it will be scrambled with
    byte_t                  seed_blk [SEED_LEN];
    int                     fill_count = 0;
    logic [ROUNDS_W-1:0]    p_rounds     = ROUNDS_RST;
    logic [ROT_WHOLE_W-1:0] p_rot_whole  = ROT_WHOLE_RST;
    logic [ROT_HALF_W-1:0]  p_rot_first  = ROT_FIRST_HALF_RST;
    logic [ROT_HALF_W-1:0]  p_rot_second = ROT_SECOND_HALF_RST;

    scr_out_t scrambled_q [$];

    int   err_count      = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;

    keyed_byte_block_scrambler_top #(
        .SEED_LEN(SEED_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_addr(cfg_addr),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(HALF_PERIOD) clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Left rotation of seed_blk[base +: len]
    function automatic void rotate_seg(int base, int len, int amount);
        byte_t tmp [SEED_LEN];
        int    a;
        a = amount % len;
        for (int k = 0; k < len; k++)
            tmp[k] = seed_blk[base + (k + a) % len];
        for (int k = 0; k < len; k++)
            seed_blk[base + k] = tmp[k];
    endfunction

    function automatic void swap_pair(int a, int b);
        byte_t t;
        t           = seed_blk[a];
        seed_blk[a] = seed_blk[b];
        seed_blk[b] = t;
    endfunction

    function automatic void scramble_block();
        logic parity;
        int   partner;
        // parity restarts odd for every block and runs on across rounds
        parity = 1'b1;
        for (int r = 0; r < p_rounds; r++)
        begin
            for (int i = 0; i < QUARTER; i++)
            begin
                partner = parity ? HALF - 2 - i : HALF - 1 - i;
                swap_pair(i, partner);
                swap_pair(HALF + i, HALF + partner);
                parity = ~parity;
            end
            rotate_seg(0, HALF, p_rot_first);
            rotate_seg(HALF, HALF, p_rot_second);
            rotate_seg(0, SEED_LEN, p_rot_whole);
        end
    endfunction

    // Store one seed byte; a full block is scrambled and queued for output
    function automatic void load_seed_byte(byte_t b);
        scr_out_t e;
        seed_blk[fill_count] = b;
        fill_count++;
        if (fill_count == SEED_LEN)
        begin
            scramble_block();
            for (int k = 0; k < SEED_LEN; k++)
            begin
                e.ch   = seed_blk[k];
                e.last = (k == SEED_LEN - 1);
                scrambled_q.push_back(e);
            end
            fill_count = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Error reporting
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ERROR: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // ---------------------------------------------------------------
    // Output side: result check
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        scr_out_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (scrambled_q.size() == 0)
                report_mismatch("output transaction with nothing pending, data",
                                int'(m_tdata), 0);
            else
            begin
                e = scrambled_q.pop_front();
                if (m_tdata !== e.ch)
                    report_mismatch("out_char", int'(m_tdata), int'(e.ch));
                if (m_tlast !== e.last)
                    report_mismatch("last_out", int'(m_tlast), int'(e.last));
            end
        end
    end

    // Output side: ready generation with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Driving tasks
    // ---------------------------------------------------------------

    // One seed byte; random gaps in front of it while the sender idles
    task automatic send_seed(input byte_t b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        load_seed_byte(b);
    endtask

    task automatic send_block();
        repeat (SEED_LEN) send_seed(byte_t'($urandom_range(255)));
    endtask

    // Register write; leaves cfg_valid high for a following write
    task automatic cfg_put(input logic [7:0] addr, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (addr)
            CFG_ROUNDS:          p_rounds     = data[ROUNDS_W-1:0];
            CFG_ROT_WHOLE:       p_rot_whole  = data[ROT_WHOLE_W-1:0];
            CFG_ROT_FIRST_HALF:  p_rot_first  = data[ROT_HALF_W-1:0];
            CFG_ROT_SECOND_HALF: p_rot_second = data[ROT_HALF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int rounds_v, input int whole_v, input int first_v,
                             input int second_v);
        cfg_put(CFG_ROUNDS, 16'(rounds_v));
        cfg_put(CFG_ROT_WHOLE, 16'(whole_v));
        cfg_put(CFG_ROT_FIRST_HALF, 16'(first_v));
        cfg_put(CFG_ROT_SECOND_HALF, 16'(second_v));
        cfg_valid <= 1'b0;
    endtask

    // Stop sending and wait until every pending byte has come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (scrambled_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset settings; byte extremes at the head of the block
    task automatic test_default_settings();
        byte_t head [8];
        head = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'hAA, 8'h55};
        set_idling(0, 0);
        foreach (head[k])
            send_seed(head[k]);
        repeat (SEED_LEN - 8) send_seed(byte_t'($urandom_range(255)));
        wait_idle();
    endtask

    // Zero rounds pass the block through; writes past the register list are dropped.
    // The sender idles most of the time.
    task automatic test_zero_rounds();
        set_idling(86, 0);
        cfg_put(8'd4, 16'hFFFF);
        cfg_put(8'hFF, 16'h0000);
        configure(0, 0, 0, 0);
        for (int k = 0; k < SEED_LEN; k++)
            send_seed(byte_t'(k * 4 + 3));
        wait_idle();
    endtask

    // Rotation by the full segment length everywhere; the receiver stalls most of the time
    task automatic test_rotation_extremes();
        set_idling(0, 86);
        configure(1, SEED_LEN, HALF, HALF);
        send_block();
        wait_idle();
    endtask

    // Settings changed mid-load; new ones: longest run, whole and first-half rotations
    // one short of the segment length, second half by one. Both sides idle a little.
    task automatic test_config_mid_load();
        set_idling(22, 22);
        configure(3, 5, 7, 9);
        repeat (20) send_seed(byte_t'($urandom_range(255)));
        wait_idle();
        configure(16'hFFFF, SEED_LEN - 1, HALF - 1, 1);
        repeat (SEED_LEN - 20) send_seed(byte_t'($urandom_range(255)));
        wait_idle();
    endtask

    // Output held off while two blocks are offered back to back, random settings
    task automatic test_backpressure();
        set_idling(0, 0);
        configure($urandom_range(40), $urandom_range(SEED_LEN), $urandom_range(HALF),
                  $urandom_range(HALF));
        hold_req = 1'b1;
        send_block();
        send_block();
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_addr  = '0;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_settings();
        test_zero_rounds();
        test_rotation_extremes();
        test_config_mid_load();
        test_backpressure();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
